[src/lpbd_pkg.sv]
// Package for the length-prefixed block deframer.
// Holds the request, kind and phase codes and the item type shared by the design modules.
// Depends on nothing.
`default_nettype none

package lpbd_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned LenBits  = 16;
  localparam int unsigned ReqBits  = 2;
  localparam int unsigned KindBits = 2;

  localparam logic [LenBits-1:0] MaxLenReset = 16'd2048;

  localparam logic [ReqBits-1:0] REQ_DATA = 2'd0;
  localparam logic [ReqBits-1:0] REQ_UP   = 2'd1;
  localparam logic [ReqBits-1:0] REQ_DOWN = 2'd2;

  localparam logic [KindBits-1:0] KIND_BYTE = 2'd0;
  localparam logic [KindBits-1:0] KIND_PING = 2'd1;
  localparam logic [KindBits-1:0] KIND_BAD  = 2'd2;

  typedef enum logic [3:0] {
    PH_DOWN    = 4'b0001,
    PH_LEN_HI  = 4'b0010,
    PH_LEN_LO  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                valid;
    logic [ReqBits-1:0]  req_type;
    logic [ByteBits-1:0] data_byte;
  } item_t;

endpackage

`default_nettype wire

[src/length_prefixed_block_deframer.sv]
// Top level of the length-prefixed block deframer.
// Instantiates lpbd_in_reg and lpbd_core; uses lpbd_pkg.
//
// Receive-side deframer for a byte stream of blocks, each a 16-bit big-endian length
// followed by that many payload bytes. Each input beat carries a request in in_tuser
// (data byte, link up, link down) and a byte in in_tdata. Once the link is up, every
// payload byte leaves as one output beat with tlast on the final byte of its block; a
// zero length gives one ping beat and a length above the configured maximum gives one
// error beat carrying the length, after which the link is down until the next link-up.
// One beat is taken per cycle unless out_tready holds the result register; a beat
// passes the input register, then the result register. The user must write the
// maximum length (reset 2048) via cfg_valid/cfg_data only while idle; not enforced.
`default_nettype none

module length_prefixed_block_deframer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data,   // max_block_len
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte
  input  wire  [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // payload_byte [7:0], bad_length [23:8]
  output logic        out_tlast,  // last_in_block
  output logic [1:0]  out_tuser   // kind
);

  lpbd_pkg::item_t item;
  logic            take;

  assign cfg_ready = 1'b1;

  lpbd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .item      (item)
  );

  lpbd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item       (item),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !item.valid |-> in_tready)
    else $error("Input refused while the input register is empty.");

  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lpbd_pkg::KIND_BAD |-> out_tdata[23:8] != 16'd0)
    else $error("Length error beat without a nonzero length.");

  a_ctrl_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lpbd_pkg::KIND_BYTE |-> !out_tlast && out_tdata[7:0] == 8'd0)
    else $error("Ping or error beat carries payload fields.");

  a_no_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == lpbd_pkg::KIND_BYTE || out_tuser == lpbd_pkg::KIND_PING ||
                   out_tuser == lpbd_pkg::KIND_BAD)
    else $error("Result beat with an undefined kind.");

endmodule

`default_nettype wire

[src/lpbd_in_reg.sv]
// Input register stage of the length-prefixed block deframer.
// Captures one input beat and holds it until the core takes it; uses lpbd_pkg.
`default_nettype none

module lpbd_in_reg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire [lpbd_pkg::ByteBits-1:0]  in_tdata,
  input  wire [lpbd_pkg::ReqBits-1:0]   in_tuser,
  input  wire                           take,
  output lpbd_pkg::item_t               item
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [lpbd_pkg::ReqBits-1:0]  req_r;
  logic [lpbd_pkg::ByteBits-1:0] data_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r  <= in_tuser;
      data_r <= in_tdata;
    end
  end

  assign item.valid     = valid_r;
  assign item.req_type  = req_r;
  assign item.data_byte = data_r;

endmodule

`default_nettype wire

[src/lpbd_core.sv]
// Deframing state and result register of the length-prefixed block deframer.
// Updates the link phase and counters per beat and registers the result; uses lpbd_pkg.
`default_nettype none

module lpbd_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  input  wire [lpbd_pkg::LenBits-1:0]   cfg_data,
  input  lpbd_pkg::item_t               item,
  output logic                          take,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [lpbd_pkg::ByteBits+lpbd_pkg::LenBits-1:0] out_tdata,
  output logic                          out_tlast,
  output logic [lpbd_pkg::KindBits-1:0] out_tuser
);

  lpbd_pkg::phase_t              phase_r, phase_nxt;
  logic [lpbd_pkg::ByteBits-1:0] len_hi_r, len_hi_nxt;
  logic [lpbd_pkg::LenBits-1:0]  blk_len_r, blk_len_nxt;
  logic [lpbd_pkg::LenBits-1:0]  rcvd_r, rcvd_nxt;
  logic [lpbd_pkg::LenBits-1:0]  max_len_r;
  logic [lpbd_pkg::LenBits-1:0]  len;
  logic [lpbd_pkg::LenBits-1:0]  rcvd_inc;

  logic                           out_v_r, out_v_nxt;
  logic [lpbd_pkg::KindBits-1:0]  kind_r, kind_nxt;
  logic [lpbd_pkg::ByteBits-1:0]  byte_r, byte_nxt;
  logic                           last_r, last_nxt;
  logic [lpbd_pkg::LenBits-1:0]   bad_r, bad_nxt;
  logic                           emit;

  assign take     = item.valid && (!out_v_r || out_tready);
  assign len      = {len_hi_r, item.data_byte};
  assign rcvd_inc = rcvd_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    len_hi_nxt  = len_hi_r;
    blk_len_nxt = blk_len_r;
    rcvd_nxt    = rcvd_r;
    emit        = 1'b0;
    kind_nxt    = lpbd_pkg::KIND_BYTE;
    byte_nxt    = '0;
    last_nxt    = 1'b0;
    bad_nxt     = '0;
    if (item.req_type == lpbd_pkg::REQ_UP) begin
      phase_nxt   = lpbd_pkg::PH_LEN_HI;
      len_hi_nxt  = '0;
      blk_len_nxt = '0;
      rcvd_nxt    = '0;
    end else if (item.req_type == lpbd_pkg::REQ_DOWN) begin
      phase_nxt   = lpbd_pkg::PH_DOWN;
      len_hi_nxt  = '0;
      blk_len_nxt = '0;
      rcvd_nxt    = '0;
    end else if (item.req_type == lpbd_pkg::REQ_DATA) begin
      unique case (phase_r)
        lpbd_pkg::PH_LEN_HI: begin
          len_hi_nxt = item.data_byte;
          phase_nxt  = lpbd_pkg::PH_LEN_LO;
        end
        lpbd_pkg::PH_LEN_LO: begin
          if (len > max_len_r) begin
            emit        = 1'b1;
            kind_nxt    = lpbd_pkg::KIND_BAD;
            bad_nxt     = len;
            phase_nxt   = lpbd_pkg::PH_DOWN;
            len_hi_nxt  = '0;
            blk_len_nxt = '0;
            rcvd_nxt    = '0;
          end else if (len == '0) begin
            emit      = 1'b1;
            kind_nxt  = lpbd_pkg::KIND_PING;
            phase_nxt = lpbd_pkg::PH_LEN_HI;
          end else begin
            blk_len_nxt = len;
            rcvd_nxt    = '0;
            phase_nxt   = lpbd_pkg::PH_PAYLOAD;
          end
        end
        lpbd_pkg::PH_PAYLOAD: begin
          emit     = 1'b1;
          byte_nxt = item.data_byte;
          rcvd_nxt = rcvd_inc;
          if (rcvd_inc >= blk_len_r) begin
            last_nxt  = 1'b1;
            phase_nxt = lpbd_pkg::PH_LEN_HI;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (take) begin
      out_v_nxt = emit;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpbd_pkg::PH_DOWN;
      len_hi_r  <= '0;
      blk_len_r <= '0;
      rcvd_r    <= '0;
      max_len_r <= lpbd_pkg::MaxLenReset;
      out_v_r   <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
      if (take) begin
        phase_r   <= phase_nxt;
        len_hi_r  <= len_hi_nxt;
        blk_len_r <= blk_len_nxt;
        rcvd_r    <= rcvd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {bad_r, byte_r};

endmodule

`default_nettype wire

[tb/lpbd_scoreboard.sv]
`timescale 1ns / 100ps
// Scoreboard for the length-prefixed block deframer. It watches the configuration, input and
// result channels, predicts each result beat and compares it with the beat that arrives.
// Depends on lpbd_pkg for the request, kind and phase codes.
module lpbd_scoreboard (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [15:0] cfg_data,   // max_block_len
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte
  input  wire  [1:0]  in_tuser,   // req_type
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [23:0] out_tdata,  // payload_byte [7:0], bad_length [23:8]
  input  wire         out_tlast,  // last_in_block
  input  wire  [1:0]  out_tuser,  // kind
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [lpbd_pkg::KindBits-1:0] kind;
    logic [lpbd_pkg::ByteBits-1:0] payload;
    logic                          last;
    logic [lpbd_pkg::LenBits-1:0]  bad_len;
  } deframed_t;

  deframed_t                     expected_q[$];
  lpbd_pkg::phase_t              link_phase;
  logic [lpbd_pkg::ByteBits-1:0] len_hi;
  logic [lpbd_pkg::LenBits-1:0]  block_len;
  logic [lpbd_pkg::LenBits-1:0]  byte_count;
  logic [lpbd_pkg::LenBits-1:0]  max_len;

  initial begin
    errors = 0;
    pending = 0;
  end

  function void clear_block_state();
    len_hi = '0;
    block_len = '0;
    byte_count = '0;
  endfunction

  function void report_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    errors++;
  endfunction

  function void advance_deframer(logic [lpbd_pkg::ReqBits-1:0] req,
                                 logic [lpbd_pkg::ByteBits-1:0] byte_in);
    logic [lpbd_pkg::LenBits-1:0] len;
    deframed_t                    r;
    r = '0;
    if (req == lpbd_pkg::REQ_UP) begin
      link_phase = lpbd_pkg::PH_LEN_HI;
      clear_block_state();
    end else if (req == lpbd_pkg::REQ_DOWN) begin
      link_phase = lpbd_pkg::PH_DOWN;
      clear_block_state();
    end else if (req == lpbd_pkg::REQ_DATA) begin
      case (link_phase)
        lpbd_pkg::PH_LEN_HI: begin
          len_hi = byte_in;
          link_phase = lpbd_pkg::PH_LEN_LO;
        end
        lpbd_pkg::PH_LEN_LO: begin
          len = {len_hi, byte_in};
          if (len > max_len) begin
            r.kind = lpbd_pkg::KIND_BAD;
            r.bad_len = len;
            expected_q.push_back(r);
            link_phase = lpbd_pkg::PH_DOWN;
            clear_block_state();
          end else if (len == '0) begin
            r.kind = lpbd_pkg::KIND_PING;
            expected_q.push_back(r);
            link_phase = lpbd_pkg::PH_LEN_HI;
          end else begin
            block_len = len;
            byte_count = '0;
            link_phase = lpbd_pkg::PH_PAYLOAD;
          end
        end
        lpbd_pkg::PH_PAYLOAD: begin
          byte_count = byte_count + 16'd1;
          r.kind = lpbd_pkg::KIND_BYTE;
          r.payload = byte_in;
          r.last = (byte_count >= block_len);
          expected_q.push_back(r);
          if (r.last) link_phase = lpbd_pkg::PH_LEN_HI;
        end
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    if (!rst_n) begin
      expected_q.delete();
      link_phase = lpbd_pkg::PH_DOWN;
      clear_block_state();
      max_len = lpbd_pkg::MaxLenReset;
    end else begin
      if (cfg_valid && cfg_ready) max_len = cfg_data;
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.payload = out_tdata[7:0];
        got.last = out_tlast;
        got.bad_len = out_tdata[23:8];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, %s %0h byte %0h last %0h len %0h",
                   $time, "got kind", got.kind, got.payload, got.last, got.bad_len);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind)
            report_field("kind", 16'(want.kind), 16'(got.kind));
          if (got.payload !== want.payload)
            report_field("payload byte", 16'(want.payload), 16'(got.payload));
          if (got.last !== want.last)
            report_field("last mark", 16'(want.last), 16'(got.last));
          if (got.bad_len !== want.bad_len)
            report_field("bad length", want.bad_len, got.bad_len);
        end
      end
      if (in_tvalid && in_tready) advance_deframer(in_tuser, in_tdata);
    end
    pending <= expected_q.size();
  end

endmodule

[tb/length_prefixed_block_deframer_tb.sv]
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, directed and random beats, receiver stalls
// and the verdict. Depends on lpbd_pkg, length_prefixed_block_deframer and lpbd_scoreboard.
module length_prefixed_block_deframer_tb;

  localparam logic [lpbd_pkg::ReqBits-1:0] REQ_UNUSED = 2'd3;

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  int          errors;
  int          pending;

  int                           burst_left = 0;
  int                           beats_counted = 0;
  bit                           link_up = 1'b0;
  logic [lpbd_pkg::LenBits-1:0] max_len_now = lpbd_pkg::MaxLenReset;
  rx_mode_t                     rx_mode = RX_OPEN;
  int                           rx_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  length_prefixed_block_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  lpbd_scoreboard scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready <= (rx_left % 5) != 0;
      default:     out_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  task automatic send_beat(logic [lpbd_pkg::ReqBits-1:0] req,
                           logic [lpbd_pkg::ByteBits-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    if (req == lpbd_pkg::REQ_UP || req == lpbd_pkg::REQ_DOWN ||
        (req == lpbd_pkg::REQ_DATA && link_up)) beats_counted++;
    if (req == lpbd_pkg::REQ_UP) link_up = 1'b1;
    if (req == lpbd_pkg::REQ_DOWN) link_up = 1'b0;
  endtask

  task automatic send_header(logic [lpbd_pkg::LenBits-1:0] len);
    send_beat(lpbd_pkg::REQ_DATA, len[15:8]);
    send_beat(lpbd_pkg::REQ_DATA, len[7:0]);
    if (len > max_len_now) link_up = 1'b0;
  endtask

  // A beat with no result may still sit in the pipeline once the last result has left.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(logic [lpbd_pkg::LenBits-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len_now = value;
  endtask

  task automatic run_phase(logic [lpbd_pkg::LenBits-1:0] limit_len, int n_items);
    int lim;
    int roll;
    int len;
    int cut;
    int stop_at;
    lim = int'(limit_len);
    stop_at = beats_counted + n_items;
    write_max_len(limit_len);
    while (beats_counted < stop_at) begin
      roll = $urandom_range(0, 99);
      if (!link_up) begin
        if (roll < 25) send_beat(lpbd_pkg::REQ_DATA, 8'($urandom));
        else send_beat(lpbd_pkg::REQ_UP, 8'($urandom));
      end else if (roll < 6) begin
        send_beat(2'($urandom_range(0, 3)), 8'($urandom));
        send_beat(lpbd_pkg::REQ_UP, 8'($urandom));
      end else begin
        if (roll < 16) len = 0;
        else if (roll < 24 && lim < 65535) len = $urandom_range(lim + 1, 65535);
        else if (lim == 0) len = 0;
        else if (roll < 30) len = $urandom_range(1, (lim < 300) ? lim : 300);
        else len = $urandom_range(1, (lim < 12) ? lim : 12);
        send_header(16'(len));
        if (len != 0 && len <= lim) begin
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
          for (int i = 0; i < cut; i++) send_beat(lpbd_pkg::REQ_DATA, 8'($urandom));
          if (cut < len) begin
            send_beat($urandom_range(0, 1) ? lpbd_pkg::REQ_UP : lpbd_pkg::REQ_DOWN,
                      8'($urandom));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Beats while the link is down, and the unused request, must vanish.
    send_beat(lpbd_pkg::REQ_DATA, 8'hFF);
    send_beat(REQ_UNUSED, 8'h00);
    send_beat(lpbd_pkg::REQ_UP, 8'h00);
    send_header(16'h0000);
    send_header(16'h0001);
    send_beat(lpbd_pkg::REQ_DATA, 8'hFF);
    send_header(16'h0003);
    send_beat(lpbd_pkg::REQ_DATA, 8'h00);
    send_beat(lpbd_pkg::REQ_DATA, 8'hA5);
    send_beat(lpbd_pkg::REQ_DATA, 8'h5A);
    // A block of exactly the maximum is accepted, then abandoned by a fresh link-up.
    send_header(lpbd_pkg::MaxLenReset);
    send_beat(lpbd_pkg::REQ_DATA, 8'h3C);
    send_beat(REQ_UNUSED, 8'hC3);
    send_beat(lpbd_pkg::REQ_UP, 8'hFF);
    send_header(lpbd_pkg::MaxLenReset + 16'd1);
    send_beat(lpbd_pkg::REQ_DATA, 8'h77);
    send_beat(lpbd_pkg::REQ_UP, 8'h00);
    send_header(16'hFFFF);
    send_beat(lpbd_pkg::REQ_DOWN, 8'h00);
    send_beat(lpbd_pkg::REQ_UP, 8'h00);
    send_header(16'h0002);
    send_beat(lpbd_pkg::REQ_DATA, 8'h11);
    send_beat(lpbd_pkg::REQ_DOWN, 8'hAA);

    run_phase(16'd1, 300);
    run_phase(16'hFFFF, 300);
    run_phase(16'd0, 300);
    run_phase(16'($urandom_range(2, 40)), 300);
    run_phase(16'($urandom_range(41, 65534)), 300);
    run_phase(lpbd_pkg::MaxLenReset, 300);

    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
src/lpbd_pkg.sv
src/lpbd_in_reg.sv
src/lpbd_core.sv
src/length_prefixed_block_deframer.sv
tb/lpbd_scoreboard.sv
tb/length_prefixed_block_deframer_tb.sv
